// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TRS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define TRS_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define TRS_ASSERT(lbl, prop)
`define TRS_ASSERT_RST(lbl, prop)
`endif
`endif

// File: rtl/trs_pkg.sv
// Shared types, constants and rounding helpers for the matrix builder.
`default_nettype none
package trs_pkg;
  typedef logic [8:0][31:0] mat3_t;
  typedef logic [2:0][31:0] vec3_t;

  // quarter-sine polynomial coefficients, Q30
  localparam logic [30:0] POLY_A = 31'd1686629713;
  localparam logic [30:0] POLY_B = 31'd688904866;
  localparam logic [30:0] POLY_C = 31'd76016977;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic signed [63:0] HALF30 = 64'sd536870912;

  function automatic logic signed [63:0] mul32(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] ae;
    logic signed [63:0] be;
    ae = 64'(a);
    be = 64'(b);
    return ae * be;
  endfunction

  // round half up, then floor shift by 30
  function automatic logic signed [33:0] rnd30(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + HALF30;
    return signed'(t[63:30]);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -34'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction
endpackage
`default_nettype wire

// File: rtl/euler_trs_matrix_builder.sv
// Top level: Euler ZYX rotation, scale and translation 4x4 matrix builder.
// Input channel item_valid/item_stall carries three binary angles, three
// Q16.16 scales and a Q16.16 position. Output channel row_valid/row_stall
// carries four matrix rows per item: row_index, elem0..elem3 and last_row.
// Rows 0..2 are the scaled rotation with elem3 = 0, row 3 is the position
// with elem3 = 1.0.
// An accepted item passes through the pipeline stages into the output
// register; its rows then follow one per cycle when not stalled.
// The single output register sends four rows per item; behind it the
// pipeline can hold further items. Eleven pipeline stages (input register,
// four sine stages, four rotation stages, two scaling stages) hold up to
// eleven items in flight; they all advance together when the output
// register frees up or the last stage is empty.
// A stall on the row channel holds the current row; once the pipeline
// backs up, item_stall rises.
// Reset empties the pipeline and the output register; no other state.
`default_nettype none
`include "assert_macros.svh"
module euler_trs_matrix_builder #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [15:0] angle_x,
  input  wire logic [15:0] angle_y,
  input  wire logic [15:0] angle_z,
  input  wire logic [31:0] scale_x,
  input  wire logic [31:0] scale_y,
  input  wire logic [31:0] scale_z,
  input  wire logic [31:0] pos_x,
  input  wire logic [31:0] pos_y,
  input  wire logic [31:0] pos_z,
  output logic             row_valid,
  input  wire logic        row_stall,
  output logic [1:0]       row_index,
  output logic [31:0]      elem0,
  output logic [31:0]      elem1,
  output logic [31:0]      elem2,
  output logic [31:0]      elem3,
  output logic             last_row
);
  localparam int ASH = 32 - ANGLE_BITS;
  localparam int NSTG = 11;
  localparam int SCD = 8;
  localparam int POSD = 10;
  localparam logic [1:0] LAST_IDX = 2'd3;
  localparam logic [31:0] ONE_Q = 32'(64'd1 << FRAC_BITS);

  logic [NSTG-1:0] vld;
  logic en, obuf_free, row_done;
  logic [15:0] ax0, ay0, az0;
  trs_pkg::vec3_t sc0, pos0;
  trs_pkg::vec3_t sc_d [SCD];
  trs_pkg::vec3_t pos_d [POSD];
  logic [31:0] phx, phy, phz;
  logic signed [31:0] sx, cx, sy, cy, sz, cz;
  trs_pkg::mat3_t rot, mres, mat;
  trs_pkg::vec3_t pos_o;
  logic [1:0] row;
  logic [3:0] base;

  // pipeline moves as one; output register takes a matrix on its last row
  assign row_done  = row_valid && !row_stall && (row == LAST_IDX);
  assign obuf_free = !row_valid || row_done;
  assign en = obuf_free || !vld[NSTG-1];
  assign item_stall = !en;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], item_valid};
    end
  end

  // input register and side delay lines
  always_ff @(posedge clk) begin
    if (en) begin
      ax0  <= angle_x;
      ay0  <= angle_y;
      az0  <= angle_z;
      sc0  <= {scale_z, scale_y, scale_x};
      pos0 <= {pos_z, pos_y, pos_x};
      sc_d[0]  <= sc0;
      pos_d[0] <= pos0;
      for (int i = 1; i < SCD; i++) sc_d[i] <= sc_d[i-1];
      for (int i = 1; i < POSD; i++) pos_d[i] <= pos_d[i-1];
    end
  end

  // angles to 32-bit turn fractions
  assign phx = {{16{ax0[15]}}, ax0} << ASH;
  assign phy = {{16{ay0[15]}}, ay0} << ASH;
  assign phz = {{16{az0[15]}}, az0} << ASH;

  trs_sine u_sx (.clk, .en, .phase(phx), .sine(sx));
  trs_sine u_cx (.clk, .en, .phase(phx + trs_pkg::QUARTER_TURN), .sine(cx));
  trs_sine u_sy (.clk, .en, .phase(phy), .sine(sy));
  trs_sine u_cy (.clk, .en, .phase(phy + trs_pkg::QUARTER_TURN), .sine(cy));
  trs_sine u_sz (.clk, .en, .phase(phz), .sine(sz));
  trs_sine u_cz (.clk, .en, .phase(phz + trs_pkg::QUARTER_TURN), .sine(cz));

  trs_rot u_rot (.clk, .en, .sx, .cx, .sy, .cy, .sz, .cz, .rot);

  trs_scale u_scale (.clk, .en, .rot, .sc(sc_d[SCD-1]), .res(mres));

  // output register and row counter
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= 1'b0;
      row       <= '0;
    end else if (obuf_free) begin
      row_valid <= vld[NSTG-1];
      row       <= '0;
    end else if (!row_stall) begin
      row <= row + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (obuf_free && vld[NSTG-1]) begin
      mat   <= mres;
      pos_o <= pos_d[POSD-1];
    end
  end

  // row select
  always_comb begin
    base      = {1'b0, row, 1'b0} + {2'b0, row};
    row_index = row;
    last_row  = (row == LAST_IDX);
    if (row == LAST_IDX) begin
      elem0 = pos_o[0];
      elem1 = pos_o[1];
      elem2 = pos_o[2];
      elem3 = ONE_Q;
    end else begin
      elem0 = mat[base];
      elem1 = mat[base + 4'd1];
      elem2 = mat[base + 4'd2];
      elem3 = '0;
    end
  end

  `TRS_ASSERT(a_row_step, row_valid && !row_stall && row != LAST_IDX |=> row_valid && row == $past(row) + 2'd1)
  `TRS_ASSERT(a_row_wrap, row_done |=> !row_valid || row == 2'd0)
  `TRS_ASSERT(a_hold_last, vld[NSTG-1] && !en |=> vld[NSTG-1])
  `TRS_ASSERT_RST(a_reset_empty, rst |=> !row_valid && vld == '0)
endmodule
`default_nettype wire

// File: rtl/trs_sine.sv
// One sine lane: quadrant fold and four-stage polynomial pipeline.
`default_nettype none
module trs_sine (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [31:0]        phase,
  output logic signed [31:0]      sine
);
  logic [30:0] xr, x0;
  logic [61:0] prod1, prod2, prod3, prod4;
  logic [30:0] x1, x2_1, x_2, x2_2, t_2, x_3, t3_3, s4;
  logic        n1, n_2, n_3, n4;

  // fold into first quadrant
  always_comb begin
    xr = {1'b0, phase[29:0]};
    x0 = phase[30] ? (trs_pkg::Q30_ONE - xr) : xr;
  end

  assign prod1 = {31'b0, x0} * {31'b0, x0};
  assign prod2 = {31'b0, trs_pkg::POLY_C} * {31'b0, x2_1};
  assign prod3 = {31'b0, trs_pkg::POLY_B - t_2} * {31'b0, x2_2};
  assign prod4 = {31'b0, trs_pkg::POLY_A - t3_3} * {31'b0, x_3};

  // one multiply per stage
  always_ff @(posedge clk) begin
    if (en) begin
      x1   <= x0;
      n1   <= phase[31];
      x2_1 <= prod1[60:30];
      t_2  <= prod2[60:30];
      x_2  <= x1;
      x2_2 <= x2_1;
      n_2  <= n1;
      t3_3 <= prod3[60:30];
      x_3  <= x_2;
      n_3  <= n_2;
      s4   <= prod4[60:30];
      n4   <= n_3;
    end
  end

  assign sine = n4 ? -signed'({1'b0, s4}) : signed'({1'b0, s4});
endmodule
`default_nettype wire

// File: rtl/trs_rot.sv
// Combines the six sines into the Rz*Ry*Rx rotation, four stages.
`default_nettype none
module trs_rot (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [31:0] sx,
  input  wire logic signed [31:0] cx,
  input  wire logic signed [31:0] sy,
  input  wire logic signed [31:0] cy,
  input  wire logic signed [31:0] sz,
  input  wire logic signed [31:0] cz,
  output trs_pkg::mat3_t          rot
);
  logic signed [63:0] p_czsy, p_szsy, p00, p10, p21, p22;
  logic signed [63:0] p_szcx, p_szsx, p_czcx, p_czsx;
  logic signed [63:0] p_szcx2, p_szsx2, p_czcx2, p_czsx2;
  logic signed [63:0] p_szcx3, p_szsx3, p_czcx3, p_czsx3;
  logic signed [63:0] q01, q02, q11, q12;
  logic signed [31:0] sx1, cx1, nsy1, sx2, cx2, czsy2, szsy2;
  logic [31:0] r00_2, r10_2, r20_2, r21_2, r22_2;
  logic [31:0] r00_3, r10_3, r20_3, r21_3, r22_3;
  logic signed [33:0] rd_czsy, rd_szsy, rd00, rd10, rd21, rd22;

  assign rd_czsy = trs_pkg::rnd30(p_czsy);
  assign rd_szsy = trs_pkg::rnd30(p_szsy);
  assign rd00 = trs_pkg::rnd30(p00);
  assign rd10 = trs_pkg::rnd30(p10);
  assign rd21 = trs_pkg::rnd30(p21);
  assign rd22 = trs_pkg::rnd30(p22);

  always_ff @(posedge clk) begin
    if (en) begin
      // pair products
      p_czsy <= trs_pkg::mul32(cz, sy);
      p_szsy <= trs_pkg::mul32(sz, sy);
      p00    <= trs_pkg::mul32(cz, cy);
      p10    <= trs_pkg::mul32(sz, cy);
      p21    <= trs_pkg::mul32(cy, sx);
      p22    <= trs_pkg::mul32(cy, cx);
      p_szcx <= trs_pkg::mul32(sz, cx);
      p_szsx <= trs_pkg::mul32(sz, sx);
      p_czcx <= trs_pkg::mul32(cz, cx);
      p_czsx <= trs_pkg::mul32(cz, sx);
      sx1    <= sx;
      cx1    <= cx;
      nsy1   <= -sy;
      // round back to Q30
      czsy2  <= rd_czsy[31:0];
      szsy2  <= rd_szsy[31:0];
      r00_2  <= rd00[31:0];
      r10_2  <= rd10[31:0];
      r21_2  <= rd21[31:0];
      r22_2  <= rd22[31:0];
      r20_2  <= nsy1;
      sx2    <= sx1;
      cx2    <= cx1;
      p_szcx2 <= p_szcx;
      p_szsx2 <= p_szsx;
      p_czcx2 <= p_czcx;
      p_czsx2 <= p_czsx;
      // triple products
      q01 <= trs_pkg::mul32(czsy2, sx2);
      q02 <= trs_pkg::mul32(czsy2, cx2);
      q11 <= trs_pkg::mul32(szsy2, sx2);
      q12 <= trs_pkg::mul32(szsy2, cx2);
      p_szcx3 <= p_szcx2;
      p_szsx3 <= p_szsx2;
      p_czcx3 <= p_czcx2;
      p_czsx3 <= p_czsx2;
      r00_3 <= r00_2;
      r10_3 <= r10_2;
      r20_3 <= r20_2;
      r21_3 <= r21_2;
      r22_3 <= r22_2;
      // sums and final rounding
      rot[0] <= r00_3;
      rot[1] <= 32'(trs_pkg::rnd30(q01 - p_szcx3));
      rot[2] <= 32'(trs_pkg::rnd30(q02 + p_szsx3));
      rot[3] <= r10_3;
      rot[4] <= 32'(trs_pkg::rnd30(q11 + p_czcx3));
      rot[5] <= 32'(trs_pkg::rnd30(q12 - p_czsx3));
      rot[6] <= r20_3;
      rot[7] <= r21_3;
      rot[8] <= r22_3;
    end
  end
endmodule
`default_nettype wire

// File: rtl/trs_scale.sv
// Nine scaling lanes: rotation entry times column scale, rounded, saturated.
`default_nettype none
module trs_scale (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire trs_pkg::mat3_t rot,
  input  wire trs_pkg::vec3_t sc,
  output trs_pkg::mat3_t      res
);
  for (genvar i = 0; i < 9; i++) begin : g_lane
    logic signed [63:0] prod;
    always_ff @(posedge clk) begin
      if (en) begin
        prod   <= trs_pkg::mul32(signed'(rot[i]), signed'(sc[i % 3]));
        res[i] <= trs_pkg::sat32(trs_pkg::rnd30(prod));
      end
    end
  end
endmodule
`default_nettype wire
